// ===== src/tss_pkg.sv =====
// Shared types and constants for the 2-SAT solver.
`timescale 1ns / 1ps
package tss_pkg;

  localparam int MAX_OUT = 32;
  localparam int VC_W = 6;
  localparam logic [VC_W-1:0] VAR_COUNT_RST = 6'd32;

  // One input transaction
  typedef struct packed {
    logic       req_type;
    logic [4:0] from_var;
    logic       from_true;
    logic [4:0] to_var;
    logic       to_true;
  } req_t;

  // One result transaction
  typedef struct packed {
    logic [4:0] var_index;
    logic       var_value;
    logic       satisfiable;
    logic       last;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;
    logic ld1;
    logic ld2;
    logic run;
    logic f_start;
    logic f_chk;
    logic f_pop;
    logic r_krd;
    logic r_kchk;
    logic r_chk;
    logic r_pop;
    logic c_rd0;
    logic c_rd1;
    logic c_cmp;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic ld_ok;
    logic s_end;
    logic start_ok;
    logic scan_end;
    logic f_edge;
    logic r_edge;
    logic sp_one;
    logic sp_zero;
    logic k_zero;
    logic lab_s;
    logic i_last;
    logic sat;
  } sts_t;

endpackage

// ===== src/two_sat_solver.sv =====
// Top level of the 2-SAT solver (Kosaraju strongly connected components).
//
//  channel  | signals                          | direction | handshake
//  ---------+----------------------------------+-----------+----------------------
//  request  | start, busy, req_i               | in        | start & !busy
//  result   | res_valid_o, res_o               | out       | one-cycle strobe
//  config   | cfg_valid_i, cfg_ready_o, data   | in        | valid & ready
//
// A load transaction makes two bit writes per matrix (S_IDLE, then S_LD2). A solve
// scans one matrix bit at a time in both DFS passes, through a read and a check
// state, over N = 2*MAX_VARS nodes, then reads and compares both literal components
// of each variable, emits the results and clears all 4^ceil(log2 N) matrix entries
// (4096 at 32). After reset the same clear pass runs before the first transaction
// is taken. Results cannot be stalled; configuration is taken every cycle.
`timescale 1ns / 1ps
module two_sat_solver #(
  parameter int MAX_VARS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  tss_pkg::req_t            req_i,
  output logic                     res_valid_o,
  output tss_pkg::res_t            res_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [tss_pkg::VC_W-1:0] cfg_data_i
);
  import tss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tss_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .req_type_i(req_i.req_type),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  tss_datapath #(.MAX_VARS(MAX_VARS)) u_dp (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_data_i,
    .req_i, .cmd_i(cmd), .sts_o(sts),
    .res_valid_o, .res_o
  );

endmodule

// ===== src/tss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tss_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/tss_ctrl.sv =====
// Sequencer for load, DFS passes, check, emit and matrix clear.
`timescale 1ns / 1ps
module tss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          req_type_i,
  input  tss_pkg::sts_t sts_i,
  output tss_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import tss_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LD2    = 4'd2;
  localparam logic [3:0] S_FSTART = 4'd3;
  localparam logic [3:0] S_FRD    = 4'd4;
  localparam logic [3:0] S_FCHK   = 4'd5;
  localparam logic [3:0] S_FPOP   = 4'd6;
  localparam logic [3:0] S_RKRD   = 4'd7;
  localparam logic [3:0] S_RKCHK  = 4'd8;
  localparam logic [3:0] S_RRD    = 4'd9;
  localparam logic [3:0] S_RCHK   = 4'd10;
  localparam logic [3:0] S_RPOP   = 4'd11;
  localparam logic [3:0] S_CRD0   = 4'd12;
  localparam logic [3:0] S_CRD1   = 4'd13;
  localparam logic [3:0] S_CCMP   = 4'd14;
  localparam logic [3:0] S_EOUT   = 4'd15;

  logic [3:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          if (req_type_i) begin
            cmd_o.run = 1'b1;
            state_d = S_FSTART;
          end else begin
            cmd_o.ld1 = 1'b1;
            if (sts_i.ld_ok) state_d = S_LD2;
          end
        end
      end
      S_LD2: begin
        cmd_o.ld2 = 1'b1;
        state_d = S_IDLE;
      end
      S_FSTART: begin
        cmd_o.f_start = 1'b1;
        if (sts_i.s_end) state_d = S_RKRD;
        else if (sts_i.start_ok) state_d = S_FRD;
      end
      S_FRD: state_d = S_FCHK;
      S_FCHK: begin
        cmd_o.f_chk = 1'b1;
        if (sts_i.scan_end) state_d = sts_i.sp_one ? S_FSTART : S_FPOP;
        else state_d = S_FRD;
      end
      S_FPOP: begin
        cmd_o.f_pop = 1'b1;
        state_d = S_FRD;
      end
      S_RKRD: begin
        cmd_o.r_krd = 1'b1;
        state_d = S_RKCHK;
      end
      S_RKCHK: begin
        cmd_o.r_kchk = 1'b1;
        if (!sts_i.lab_s) state_d = S_RRD;
        else state_d = sts_i.k_zero ? S_CRD0 : S_RKRD;
      end
      S_RRD: state_d = S_RCHK;
      S_RCHK: begin
        cmd_o.r_chk = 1'b1;
        if (!sts_i.scan_end) state_d = S_RRD;
        else if (!sts_i.sp_zero) state_d = S_RPOP;
        else state_d = sts_i.k_zero ? S_CRD0 : S_RKRD;
      end
      S_RPOP: begin
        cmd_o.r_pop = 1'b1;
        state_d = S_RRD;
      end
      S_CRD0: begin
        cmd_o.c_rd0 = 1'b1;
        state_d = S_CRD1;
      end
      S_CRD1: begin
        cmd_o.c_rd1 = 1'b1;
        state_d = S_CCMP;
      end
      S_CCMP: begin
        cmd_o.c_cmp = 1'b1;
        state_d = sts_i.i_last ? S_EOUT : S_CRD0;
      end
      S_EOUT: begin
        cmd_o.emit = 1'b1;
        if (!sts_i.sat || sts_i.i_last) state_d = S_CLR;
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== src/tss_datapath.sv =====
// Matrices, DFS stack, finish order, component labels and result register.
`timescale 1ns / 1ps
module tss_datapath #(
  parameter int MAX_VARS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [tss_pkg::VC_W-1:0]  cfg_data_i,
  input  tss_pkg::req_t             req_i,
  input  tss_pkg::cmd_t             cmd_i,
  output tss_pkg::sts_t             sts_o,
  output logic                      res_valid_o,
  output tss_pkg::res_t             res_o
);
  import tss_pkg::*;

  localparam int NODES = 2 * MAX_VARS;
  localparam int LW = $clog2(NODES);
  localparam int NW = LW + 1;
  localparam int AW = (NW > 7) ? NW : 7;
  localparam int MW = 2 * LW;
  localparam int SW = LW + NW;
  localparam int NCAP = (MAX_VARS < MAX_OUT) ? MAX_VARS : MAX_OUT;

  // true when a node's variable is below the active count
  function automatic logic node_act(logic [LW-1:0] nd, logic [VC_W-1:0] n);
    logic [AW-1:0] x;
    x = AW'(nd);
    if (x >= AW'(MAX_VARS)) x = x - AW'(MAX_VARS);
    return x < AW'(n);
  endfunction

  // literal to node: true literal is the variable, false is offset by MAX_VARS
  function automatic logic [LW-1:0] lit(logic [4:0] v, logic pos);
    logic [AW-1:0] x;
    x = AW'(v);
    if (!pos) x = x + AW'(MAX_VARS);
    return LW'(x);
  endfunction

  logic [VC_W-1:0] var_count_q, n_q, i_q;
  logic [AW-1:0]   vcw;
  logic [VC_W-1:0] n_eff;
  logic [MW-1:0]   clr_addr_q;
  logic [LW-1:0]   na_q, nb_q, cur_v_q;
  logic [NW-1:0]   cur_j_q, sp_q, fc_q, s_q, k_q, num_q, comp_a_q;
  logic [NODES-1:0] visited_q, labeled_q;
  logic [MAX_OUT-1:0] val_q;
  logic            sat_q;
  logic            res_valid_q;
  res_t            res_q;

  logic [LW-1:0] a_n, b_n, na_n, nb_n, j_node, s_node;
  logic          ld_ok, scan_end, s_end, start_ok, f_edge, r_edge, lab_s, i_last;
  logic [0:0]    fwd_rd, rev_rd;
  logic          fwd_we, rev_we;
  logic [MW-1:0] fwd_waddr, rev_waddr, mat_raddr;
  logic [LW-1:0] fin_rd;
  logic [SW-1:0] stk_rd, stk_wdata;
  logic          stk_we, fin_we, comp_we;
  logic [LW-1:0] stk_waddr, stk_raddr, comp_waddr, comp_raddr;
  logic [NW-1:0] comp_rd, comp_wdata;

  // effective variable count: zero acts as one, capped at the smaller of MAX_VARS and MAX_OUT
  always_comb begin
    vcw = AW'(var_count_q);
    if (vcw == '0) n_eff = VC_W'(1);
    else if (vcw > AW'(NCAP)) n_eff = VC_W'(NCAP);
    else n_eff = var_count_q;
  end

  // load literals
  assign a_n  = lit(req_i.from_var, req_i.from_true);
  assign b_n  = lit(req_i.to_var, req_i.to_true);
  assign na_n = lit(req_i.from_var, !req_i.from_true);
  assign nb_n = lit(req_i.to_var, !req_i.to_true);
  assign ld_ok = (AW'(req_i.from_var) < AW'(MAX_VARS)) &&
                 (AW'(req_i.to_var) < AW'(MAX_VARS));

  // scan and start conditions
  assign j_node   = cur_j_q[LW-1:0];
  assign s_node   = s_q[LW-1:0];
  assign scan_end = (cur_j_q == NW'(NODES));
  assign s_end    = (s_q == NW'(NODES));
  assign start_ok = !s_end && node_act(s_node, n_q) && !visited_q[s_node];
  assign f_edge   = !scan_end && fwd_rd[0] && node_act(j_node, n_q) && !visited_q[j_node];
  assign r_edge   = !scan_end && rev_rd[0] && node_act(j_node, n_q) && !labeled_q[j_node];
  assign lab_s    = labeled_q[fin_rd];
  assign i_last   = (i_q == n_q - VC_W'(1));

  assign sts_o.clr_last = &clr_addr_q;
  assign sts_o.ld_ok    = ld_ok;
  assign sts_o.s_end    = s_end;
  assign sts_o.start_ok = start_ok;
  assign sts_o.scan_end = scan_end;
  assign sts_o.f_edge   = f_edge;
  assign sts_o.r_edge   = r_edge;
  assign sts_o.sp_one   = (sp_q == NW'(1));
  assign sts_o.sp_zero  = (sp_q == '0);
  assign sts_o.k_zero   = (k_q == '0);
  assign sts_o.lab_s    = lab_s;
  assign sts_o.i_last   = i_last;
  assign sts_o.sat      = sat_q;

  // adjacency matrices, one bit per entry, addressed {row, column}
  assign fwd_we    = cmd_i.clr | (cmd_i.ld1 & ld_ok) | cmd_i.ld2;
  assign rev_we    = fwd_we;
  assign fwd_waddr = cmd_i.clr ? clr_addr_q : (cmd_i.ld1 ? {a_n, b_n} : {nb_q, na_q});
  assign rev_waddr = cmd_i.clr ? clr_addr_q : (cmd_i.ld1 ? {b_n, a_n} : {na_q, nb_q});
  assign mat_raddr = {cur_v_q, j_node};

  tss_ram #(.W(1), .D(1 << MW)) u_fwd (
    .clk_i, .we_i(fwd_we), .waddr_i(fwd_waddr), .wdata_i(!cmd_i.clr),
    .raddr_i(mat_raddr), .rdata_o(fwd_rd)
  );

  tss_ram #(.W(1), .D(1 << MW)) u_rev (
    .clk_i, .we_i(rev_we), .waddr_i(rev_waddr), .wdata_i(!cmd_i.clr),
    .raddr_i(mat_raddr), .rdata_o(rev_rd)
  );

  // walk stack: forward entries hold {node, resume column}
  assign stk_we    = (cmd_i.f_chk & f_edge) | (cmd_i.r_chk & r_edge);
  assign stk_waddr = cmd_i.f_chk ? LW'(sp_q - NW'(1)) : LW'(sp_q);
  assign stk_wdata = cmd_i.f_chk ? {cur_v_q, cur_j_q + NW'(1)} : {j_node, NW'(0)};
  assign stk_raddr = cmd_i.f_chk ? LW'(sp_q - NW'(2)) : LW'(sp_q - NW'(1));

  tss_ram #(.W(SW), .D(1 << LW)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rd)
  );

  // finish order
  assign fin_we = cmd_i.f_chk & scan_end;

  tss_ram #(.W(LW), .D(1 << LW)) u_fin (
    .clk_i, .we_i(fin_we), .waddr_i(LW'(fc_q)), .wdata_i(cur_v_q),
    .raddr_i(LW'(k_q - NW'(1))), .rdata_o(fin_rd)
  );

  // component numbers
  assign comp_we    = (cmd_i.r_kchk & !lab_s) | (cmd_i.r_chk & r_edge);
  assign comp_waddr = cmd_i.r_kchk ? fin_rd : j_node;
  assign comp_wdata = cmd_i.r_kchk ? num_q + NW'(1) : num_q;
  assign comp_raddr = cmd_i.c_rd0 ? LW'(i_q) : LW'(AW'(i_q) + AW'(MAX_VARS));

  tss_ram #(.W(NW), .D(1 << LW)) u_comp (
    .clk_i, .we_i(comp_we), .waddr_i(comp_waddr), .wdata_i(comp_wdata),
    .raddr_i(comp_raddr), .rdata_o(comp_rd)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_count_q <= VAR_COUNT_RST;
      clr_addr_q  <= '0;
      n_q         <= VC_W'(1);
      i_q         <= '0;
      sp_q        <= '0;
      fc_q        <= '0;
      s_q         <= '0;
      k_q         <= '0;
      num_q       <= '0;
      sat_q       <= 1'b1;
      visited_q   <= '0;
      labeled_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) var_count_q <= cfg_data_i;
      if (cmd_i.clr) clr_addr_q <= clr_addr_q + MW'(1);
      res_valid_q <= cmd_i.emit;
      if (cmd_i.run) begin
        n_q       <= n_eff;
        i_q       <= '0;
        sp_q      <= '0;
        fc_q      <= '0;
        s_q       <= '0;
        num_q     <= '0;
        sat_q     <= 1'b1;
        visited_q <= '0;
        labeled_q <= '0;
      end
      if (cmd_i.f_start) begin
        if (s_end) begin
          k_q  <= fc_q;
          sp_q <= '0;
        end else begin
          s_q <= s_q + NW'(1);
          if (start_ok) begin
            visited_q[s_node] <= 1'b1;
            sp_q <= NW'(1);
          end
        end
      end
      if (cmd_i.f_chk) begin
        if (scan_end) begin
          fc_q <= fc_q + NW'(1);
          sp_q <= sp_q - NW'(1);
        end else if (f_edge) begin
          visited_q[j_node] <= 1'b1;
          sp_q <= sp_q + NW'(1);
        end
      end
      if (cmd_i.r_krd) k_q <= k_q - NW'(1);
      if (cmd_i.r_kchk && !lab_s) begin
        labeled_q[fin_rd] <= 1'b1;
        num_q <= num_q + NW'(1);
      end
      if (cmd_i.r_chk) begin
        if (scan_end) begin
          if (sp_q != '0) sp_q <= sp_q - NW'(1);
        end else if (r_edge) begin
          labeled_q[j_node] <= 1'b1;
          sp_q <= sp_q + NW'(1);
        end
      end
      if (cmd_i.c_cmp) begin
        if (comp_a_q == comp_rd) sat_q <= 1'b0;
        i_q <= i_last ? '0 : i_q + VC_W'(1);
      end
      if (cmd_i.emit) i_q <= i_q + VC_W'(1);
    end
  end

  // walk position, load latches, compare data and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld1) begin
      na_q <= na_n;
      nb_q <= nb_n;
    end
    if (cmd_i.f_start && start_ok) begin
      cur_v_q <= s_node;
      cur_j_q <= '0;
    end
    if (cmd_i.f_chk && !scan_end) begin
      if (f_edge) begin
        cur_v_q <= j_node;
        cur_j_q <= '0;
      end else begin
        cur_j_q <= cur_j_q + NW'(1);
      end
    end
    if (cmd_i.f_pop) {cur_v_q, cur_j_q} <= stk_rd;
    if (cmd_i.r_kchk && !lab_s) begin
      cur_v_q <= fin_rd;
      cur_j_q <= '0;
    end
    if (cmd_i.r_chk && !scan_end) cur_j_q <= cur_j_q + NW'(1);
    if (cmd_i.r_pop) begin
      cur_v_q <= stk_rd[SW-1:NW];
      cur_j_q <= '0;
    end
    if (cmd_i.c_rd1) comp_a_q <= comp_rd;
    if (cmd_i.c_cmp) val_q[i_q[4:0]] <= (comp_a_q > comp_rd);
    if (cmd_i.emit) begin
      if (sat_q) begin
        res_q.var_index   <= i_q[4:0];
        res_q.var_value   <= val_q[i_q[4:0]];
        res_q.satisfiable <= 1'b1;
        res_q.last        <= i_last;
      end else begin
        res_q.var_index   <= '0;
        res_q.var_value   <= 1'b0;
        res_q.satisfiable <= 1'b0;
        res_q.last        <= 1'b1;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // finish list never overflows
  a_fin_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.f_chk && scan_end) |-> (fc_q < NW'(NODES)))
    else $error("finish order overflow");

  // forward push always has stack room
  a_stk_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.f_chk && f_edge) |-> (sp_q < NW'(NODES)))
    else $error("walk stack overflow");

  // every active variable has both literals numbered before the check
  a_labeled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.c_rd0 |-> (labeled_q[LW'(i_q)] &&
                     labeled_q[LW'(AW'(i_q) + AW'(MAX_VARS))]))
    else $error("literal left without a component");

  // an unsatisfiable report is always the final result
  a_unsat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.satisfiable) |-> res_q.last)
    else $error("unsatisfiable result not marked last");

endmodule
